@@ design/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// SCC labeling engine package
// Shared widths, request and status codes, vertex record and FSM state type.
// ----------------------------------------------------------------------------
`default_nettype none
package scc_pkg;

  localparam int NV  = 1024;
  localparam int NE  = 4096;
  localparam int VW  = 10;
  localparam int EW  = 12;
  localparam int CW  = 13;
  localparam int TW  = 12;
  localparam int RAW = 11;
  localparam int CCW = 11;
  localparam int SW  = 11;

  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_RUN   = 3'd1;
  localparam logic [2:0] REQ_QVERT = 3'd2;
  localparam logic [2:0] REQ_QEDGE = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] CLR_RESET = 2'd0;
  localparam logic [1:0] CLR_GRAPH = 2'd1;
  localparam logic [1:0] CLR_RUN   = 2'd2;

  localparam logic [VW:0] PARENT_NONE = {(VW+1){1'b1}};

  typedef enum logic [1:0] {COL_WHITE, COL_GRAY, COL_BLACK} color_t;

  typedef struct packed {
    color_t          color;
    logic [TW-1:0]   disc;
    logic [TW-1:0]   fin;
    logic [TW-1:0]   low;
    logic [VW:0]     parent;
    logic            onstk;
    logic [VW-1:0]   comp;
  } vrec_t;

  localparam vrec_t VREC_RST = '{color: COL_WHITE, disc: '0, fin: '0, low: '0,
                                 parent: PARENT_NONE, onstk: 1'b0, comp: '0};

  typedef struct packed {
    logic [VW-1:0] u;
    logic [CW-1:0] k;
    logic [CW-1:0] e;
  } frame_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_LOAD_P2, S_QV, S_QE1, S_QE2, S_QE3, S_RB_RD, S_RB_CMP,
    S_ROOT_RD, S_ROOT_CHK, S_DISC1, S_DISC2, S_DISC3, S_STEP, S_EW, S_EV,
    S_FIN, S_MP_RD, S_MP_W, S_MP_M, S_FIN_WB, S_POP
  } state_t;

endpackage
`default_nettype wire

@@ design/scc_ram.sv @@
// ----------------------------------------------------------------------------
// SCC generic RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
`default_nettype none
module scc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output      logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/scc_labeling_engine_top.sv @@
// ----------------------------------------------------------------------------
// SCC labeling engine
// Edge store, row index build and iterative Tarjan search over on-chip RAMs.
// ----------------------------------------------------------------------------
//  channel | ports                                   | transaction
//  in      | start, busy, in_*                       | start && !busy
//  out     | out_valid, out_*                        | out_valid, one cycle
//
//  Load writes the edge, then marks the destination present. Edge query reads
//  the edge, then the component of each end. Clear sweeps the vertex RAMs.
//  Run builds the row index, clears the vertex records, then walks every edge
//  and vertex. After reset a sweep clears the vertex RAMs with busy high.
//  Results cannot be stalled; busy holds off new transactions.
// ----------------------------------------------------------------------------
`default_nettype none
module scc_labeling_engine_top
  import scc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output      logic          busy,
  input  wire logic [2:0]    in_req_type,
  input  wire logic [9:0]    in_src_vertex,
  input  wire logic [9:0]    in_dst_vertex,
  input  wire logic [9:0]    in_vertex_index,
  input  wire logic [11:0]   in_edge_index,
  output      logic          out_valid,
  output      logic [1:0]    out_status,
  output      logic [10:0]   out_comp_count,
  output      logic          out_present,
  output      logic [9:0]    out_comp_id,
  output      logic [11:0]   out_disc_time,
  output      logic [11:0]   out_finish_time,
  output      logic [11:0]   out_low_link,
  output      logic          out_is_cross,
  output      logic [9:0]    out_comp_from,
  output      logic [9:0]    out_comp_to,
  output      logic [9:0]    out_edge_src,
  output      logic [9:0]    out_edge_dst
);

  state_t state_r, state_nxt;

  logic [VW-1:0]  s_r, s_nxt, d_r, d_nxt, vi_r, vi_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt, eidx_r, eidx_nxt;
  logic [VW-1:0]  ls_r, ls_nxt, ld_r, ld_nxt;
  logic [TW-1:0]  t_r, t_nxt;
  logic [CCW-1:0] cc_r, cc_nxt;
  logic [SW-1:0]  sp_r, sp_nxt, msp_r, msp_nxt;
  logic [VW-1:0]  root_r, root_nxt;
  logic [RAW-1:0] addr_r, addr_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [VW-1:0]  top_u_r, top_u_nxt, w_r, w_nxt, cf_r, cf_nxt;
  logic [CW-1:0]  top_k_r, top_k_nxt, top_e_r, top_e_nxt;
  logic [TW-1:0]  clow_r, clow_nxt;
  vrec_t          rec_r, rec_nxt;

  logic           ov_r, ov_nxt;
  logic [1:0]     o_status_r, o_status_nxt;
  logic [10:0]    o_cc_r, o_cc_nxt;
  logic           o_pres_r, o_pres_nxt, o_cross_r, o_cross_nxt;
  logic [9:0]     o_comp_r, o_comp_nxt, o_cf_r, o_cf_nxt, o_ct_r, o_ct_nxt;
  logic [9:0]     o_es_r, o_es_nxt, o_ed_r, o_ed_nxt;
  logic [11:0]    o_disc_r, o_disc_nxt, o_fin_r, o_fin_nxt, o_low_r, o_low_nxt;

  logic           es_we, es_re, ed_we, ed_re;
  logic [EW-1:0]  es_waddr, es_raddr, ed_waddr, ed_raddr;
  logic [VW-1:0]  es_wdata, es_rdata, ed_wdata, ed_rdata;
  logic           rw_we, rw_re;
  logic [RAW-1:0] rw_waddr, rw_raddr;
  logic [CW-1:0]  rw_wdata, rw_rdata;
  logic           pr_we, pr_re, pr_wdata, pr_rdata;
  logic [VW-1:0]  pr_waddr, pr_raddr;
  logic           vr_we, vr_re;
  logic [VW-1:0]  vr_waddr, vr_raddr;
  vrec_t          vr_wdata, vr_rdata;
  logic           st_we, st_re;
  logic [VW-1:0]  st_waddr, st_raddr;
  frame_t         st_wdata, st_rdata;
  logic           mb_we, mb_re;
  logic [VW-1:0]  mb_waddr, mb_raddr, mb_wdata, mb_rdata;

  logic           accept;
  logic           load_ok;

  scc_ram #(.W(VW), .D(NE)) u_esrc (.clk, .we(es_we), .waddr(es_waddr),
    .wdata(es_wdata), .re(es_re), .raddr(es_raddr), .rdata(es_rdata));
  scc_ram #(.W(VW), .D(NE)) u_edst (.clk, .we(ed_we), .waddr(ed_waddr),
    .wdata(ed_wdata), .re(ed_re), .raddr(ed_raddr), .rdata(ed_rdata));
  scc_ram #(.W(CW), .D(2*NV)) u_row (.clk, .we(rw_we), .waddr(rw_waddr),
    .wdata(rw_wdata), .re(rw_re), .raddr(rw_raddr), .rdata(rw_rdata));
  scc_ram #(.W(1), .D(NV)) u_pres (.clk, .we(pr_we), .waddr(pr_waddr),
    .wdata(pr_wdata), .re(pr_re), .raddr(pr_raddr), .rdata(pr_rdata));
  scc_ram #(.W($bits(vrec_t)), .D(NV)) u_vert (.clk, .we(vr_we), .waddr(vr_waddr),
    .wdata(vr_wdata), .re(vr_re), .raddr(vr_raddr), .rdata(vr_rdata));
  scc_ram #(.W($bits(frame_t)), .D(NV)) u_stk (.clk, .we(st_we), .waddr(st_waddr),
    .wdata(st_wdata), .re(st_re), .raddr(st_raddr), .rdata(st_rdata));
  scc_ram #(.W(VW), .D(NV)) u_memb (.clk, .we(mb_we), .waddr(mb_waddr),
    .wdata(mb_wdata), .re(mb_re), .raddr(mb_raddr), .rdata(mb_rdata));

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign load_ok = (cnt_r == '0) || (in_src_vertex > ls_r) ||
                   ((in_src_vertex == ls_r) && (in_dst_vertex > ld_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_LOAD:  state_nxt = (cnt_r != CW'(NE) && load_ok) ? S_LOAD_P2 : S_IDLE;
            REQ_RUN:   state_nxt = S_RB_RD;
            REQ_QVERT: state_nxt = S_QV;
            REQ_QEDGE: state_nxt = ({1'b0, in_edge_index} >= cnt_r) ? S_IDLE : S_QE1;
            REQ_CLEAR: state_nxt = S_CLR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        if (addr_r == RAW'(NV-1)) begin
          state_nxt = (mode_r == CLR_RUN) ? S_ROOT_RD : S_IDLE;
        end
      end
      S_LOAD_P2: state_nxt = S_IDLE;
      S_QV:      state_nxt = S_IDLE;
      S_QE1:     state_nxt = S_QE2;
      S_QE2:     state_nxt = S_QE3;
      S_QE3:     state_nxt = S_IDLE;
      S_RB_RD:   state_nxt = S_RB_CMP;
      S_RB_CMP: begin
        if (eidx_r < cnt_r && {1'b0, es_rdata} < addr_r) begin
          state_nxt = S_RB_RD;
        end else if (addr_r == RAW'(NV)) begin
          state_nxt = S_CLR;
        end
      end
      S_ROOT_RD: state_nxt = S_ROOT_CHK;
      S_ROOT_CHK: begin
        if (pr_rdata && vr_rdata.color == COL_WHITE) begin
          state_nxt = S_DISC1;
        end else begin
          state_nxt = (root_r == VW'(NV-1)) ? S_IDLE : S_ROOT_RD;
        end
      end
      S_DISC1: state_nxt = S_DISC2;
      S_DISC2: state_nxt = S_DISC3;
      S_DISC3: state_nxt = S_STEP;
      S_STEP:  state_nxt = (top_k_r < top_e_r) ? S_EW : S_FIN;
      S_EW:    state_nxt = S_EV;
      S_EV:    state_nxt = (vr_rdata.color == COL_WHITE) ? S_DISC1 : S_STEP;
      S_FIN:   state_nxt = (rec_r.low == rec_r.disc) ? S_MP_RD : S_FIN_WB;
      S_MP_RD: state_nxt = S_MP_W;
      S_MP_W:  state_nxt = (mb_rdata == top_u_r) ? S_FIN_WB : S_MP_M;
      S_MP_M:  state_nxt = S_MP_RD;
      S_FIN_WB: begin
        if (sp_r != '0) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = (root_r == VW'(NV-1)) ? S_IDLE : S_ROOT_RD;
        end
      end
      S_POP:   state_nxt = S_STEP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    s_nxt = s_r; d_nxt = d_r; vi_nxt = vi_r;
    cnt_nxt = cnt_r; eidx_nxt = eidx_r; ls_nxt = ls_r; ld_nxt = ld_r;
    t_nxt = t_r; cc_nxt = cc_r; sp_nxt = sp_r; msp_nxt = msp_r;
    root_nxt = root_r; addr_nxt = addr_r; mode_nxt = mode_r;
    top_u_nxt = top_u_r; top_k_nxt = top_k_r; top_e_nxt = top_e_r;
    w_nxt = w_r; cf_nxt = cf_r; clow_nxt = clow_r; rec_nxt = rec_r;
    ov_nxt = 1'b0;
    o_status_nxt = o_status_r; o_cc_nxt = o_cc_r; o_pres_nxt = o_pres_r;
    o_comp_nxt = o_comp_r; o_disc_nxt = o_disc_r; o_fin_nxt = o_fin_r;
    o_low_nxt = o_low_r; o_cross_nxt = o_cross_r; o_cf_nxt = o_cf_r;
    o_ct_nxt = o_ct_r; o_es_nxt = o_es_r; o_ed_nxt = o_ed_r;
    es_we = 1'b0; es_waddr = cnt_r[EW-1:0]; es_wdata = in_src_vertex;
    es_re = 1'b0; es_raddr = eidx_r[EW-1:0];
    ed_we = 1'b0; ed_waddr = cnt_r[EW-1:0]; ed_wdata = in_dst_vertex;
    ed_re = 1'b0; ed_raddr = top_k_r[EW-1:0];
    rw_we = 1'b0; rw_waddr = addr_r; rw_wdata = eidx_r;
    rw_re = 1'b0; rw_raddr = {1'b0, top_u_r};
    pr_we = 1'b0; pr_waddr = addr_r[VW-1:0]; pr_wdata = 1'b0;
    pr_re = 1'b0; pr_raddr = root_r;
    vr_we = 1'b0; vr_waddr = top_u_r; vr_wdata = rec_r;
    vr_re = 1'b0; vr_raddr = root_r;
    st_we = 1'b0; st_waddr = sp_r[VW-1:0];
    st_wdata = '{u: top_u_r, k: top_k_r, e: top_e_r};
    st_re = 1'b0; st_raddr = sp_r[VW-1:0] - VW'(1);
    mb_we = 1'b0; mb_waddr = msp_r[VW-1:0]; mb_wdata = top_u_r;
    mb_re = 1'b0; mb_raddr = msp_r[VW-1:0] - VW'(1);

    if ((state_r == S_IDLE && accept) || state_r == S_LOAD_P2 || state_r == S_QV ||
        state_r == S_QE3 || (state_r == S_CLR && addr_r == RAW'(NV-1)) ||
        state_r == S_ROOT_CHK || state_r == S_FIN_WB) begin
      o_status_nxt = ST_OK; o_cc_nxt = cc_r; o_pres_nxt = 1'b0; o_comp_nxt = '0;
      o_disc_nxt = '0; o_fin_nxt = '0; o_low_nxt = '0; o_cross_nxt = 1'b0;
      o_cf_nxt = '0; o_ct_nxt = '0; o_es_nxt = '0; o_ed_nxt = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          s_nxt = in_src_vertex; d_nxt = in_dst_vertex; vi_nxt = in_vertex_index;
          case (in_req_type)
            REQ_LOAD: begin
              if (cnt_r == CW'(NE)) begin
                ov_nxt = 1'b1; o_status_nxt = ST_FULL;
              end else if (!load_ok) begin
                ov_nxt = 1'b1;
              end else begin
                es_we = 1'b1; ed_we = 1'b1;
                pr_we = 1'b1; pr_waddr = in_src_vertex; pr_wdata = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
                ls_nxt = in_src_vertex; ld_nxt = in_dst_vertex;
              end
            end
            REQ_RUN: begin
              addr_nxt = '0; eidx_nxt = '0; cc_nxt = '0; t_nxt = '0;
              sp_nxt = '0; msp_nxt = '0; root_nxt = '0;
            end
            REQ_QVERT: begin
              pr_re = 1'b1; pr_raddr = in_vertex_index;
              vr_re = 1'b1; vr_raddr = in_vertex_index;
            end
            REQ_QEDGE: begin
              if ({1'b0, in_edge_index} >= cnt_r) begin
                ov_nxt = 1'b1; o_status_nxt = ST_RANGE;
              end else begin
                es_re = 1'b1; es_raddr = in_edge_index;
                ed_re = 1'b1; ed_raddr = in_edge_index;
              end
            end
            REQ_CLEAR: begin
              cnt_nxt = '0; cc_nxt = '0; t_nxt = '0; sp_nxt = '0; msp_nxt = '0;
              addr_nxt = '0; mode_nxt = CLR_GRAPH;
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        vr_we = 1'b1; vr_waddr = addr_r[VW-1:0]; vr_wdata = VREC_RST;
        pr_we = (mode_r != CLR_RUN);
        addr_nxt = addr_r + RAW'(1);
        if (addr_r == RAW'(NV-1)) begin
          root_nxt = '0;
          ov_nxt = (mode_r == CLR_GRAPH);
        end
      end
      S_LOAD_P2: begin
        pr_we = 1'b1; pr_waddr = d_r; pr_wdata = 1'b1;
        ov_nxt = 1'b1;
      end
      S_QV: begin
        ov_nxt = 1'b1;
        o_pres_nxt = pr_rdata;
        o_comp_nxt = pr_rdata ? vr_rdata.comp : '0;
        o_disc_nxt = vr_rdata.disc; o_fin_nxt = vr_rdata.fin; o_low_nxt = vr_rdata.low;
      end
      S_QE1: begin
        s_nxt = es_rdata; d_nxt = ed_rdata;
        vr_re = 1'b1; vr_raddr = es_rdata;
      end
      S_QE2: begin
        cf_nxt = vr_rdata.comp;
        vr_re = 1'b1; vr_raddr = d_r;
      end
      S_QE3: begin
        ov_nxt = 1'b1;
        o_cross_nxt = (cf_r != vr_rdata.comp);
        o_cf_nxt = cf_r; o_ct_nxt = vr_rdata.comp;
        o_es_nxt = s_r; o_ed_nxt = d_r;
      end
      S_RB_RD: begin
        es_re = 1'b1;
      end
      S_RB_CMP: begin
        if (eidx_r < cnt_r && {1'b0, es_rdata} < addr_r) begin
          eidx_nxt = eidx_r + CW'(1);
        end else begin
          rw_we = 1'b1;
          if (addr_r == RAW'(NV)) begin
            addr_nxt = '0; mode_nxt = CLR_RUN;
          end else begin
            addr_nxt = addr_r + RAW'(1);
          end
        end
      end
      S_ROOT_RD: begin
        pr_re = 1'b1; vr_re = 1'b1;
      end
      S_ROOT_CHK: begin
        if (pr_rdata && vr_rdata.color == COL_WHITE) begin
          t_nxt = t_r + TW'(1);
          rec_nxt = '{color: COL_GRAY, disc: t_r + TW'(1), fin: '0, low: t_r + TW'(1),
                      parent: PARENT_NONE, onstk: 1'b1, comp: '0};
          top_u_nxt = root_r;
          mb_we = 1'b1; mb_wdata = root_r;
          msp_nxt = msp_r + SW'(1);
        end else if (root_r == VW'(NV-1)) begin
          ov_nxt = 1'b1;
        end else begin
          root_nxt = root_r + VW'(1);
        end
      end
      S_DISC1: begin
        vr_we = 1'b1;
        rw_re = 1'b1;
      end
      S_DISC2: begin
        top_k_nxt = rw_rdata;
        rw_re = 1'b1; rw_raddr = {1'b0, top_u_r} + RAW'(1);
      end
      S_DISC3: begin
        top_e_nxt = rw_rdata;
      end
      S_STEP: begin
        if (top_k_r < top_e_r) begin
          ed_re = 1'b1;
          top_k_nxt = top_k_r + CW'(1);
        end else begin
          t_nxt = t_r + TW'(1);
        end
      end
      S_EW: begin
        w_nxt = ed_rdata;
        vr_re = 1'b1; vr_raddr = ed_rdata;
      end
      S_EV: begin
        if (vr_rdata.color == COL_WHITE) begin
          st_we = 1'b1;
          sp_nxt = sp_r + SW'(1);
          vr_we = 1'b1;
          t_nxt = t_r + TW'(1);
          rec_nxt = '{color: COL_GRAY, disc: t_r + TW'(1), fin: '0, low: t_r + TW'(1),
                      parent: {1'b0, top_u_r}, onstk: 1'b1, comp: '0};
          top_u_nxt = w_r;
          mb_we = 1'b1; mb_wdata = w_r;
          msp_nxt = msp_r + SW'(1);
        end else if (vr_rdata.onstk && vr_rdata.disc < rec_r.low) begin
          rec_nxt.low = vr_rdata.disc;
        end
      end
      S_FIN: begin
        rec_nxt.fin = t_r;
        rec_nxt.color = COL_BLACK;
      end
      S_MP_RD: begin
        mb_re = 1'b1;
        msp_nxt = msp_r - SW'(1);
      end
      S_MP_W: begin
        if (mb_rdata == top_u_r) begin
          rec_nxt.onstk = 1'b0;
          rec_nxt.comp = cc_r[VW-1:0];
          cc_nxt = cc_r + CCW'(1);
        end else begin
          w_nxt = mb_rdata;
          vr_re = 1'b1; vr_raddr = mb_rdata;
        end
      end
      S_MP_M: begin
        vr_we = 1'b1; vr_waddr = w_r;
        vr_wdata = vr_rdata;
        vr_wdata.onstk = 1'b0;
        vr_wdata.comp = cc_r[VW-1:0];
      end
      S_FIN_WB: begin
        vr_we = 1'b1;
        if (sp_r != '0) begin
          st_re = 1'b1;
          vr_re = 1'b1; vr_raddr = rec_r.parent[VW-1:0];
          clow_nxt = rec_r.low;
          sp_nxt = sp_r - SW'(1);
        end else if (root_r == VW'(NV-1)) begin
          ov_nxt = 1'b1;
        end else begin
          root_nxt = root_r + VW'(1);
        end
      end
      S_POP: begin
        top_u_nxt = st_rdata.u; top_k_nxt = st_rdata.k; top_e_nxt = st_rdata.e;
        rec_nxt = vr_rdata;
        if (clow_r < vr_rdata.low) begin
          rec_nxt.low = clow_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      mode_r  <= CLR_RESET;
      addr_r  <= '0;
      cnt_r   <= '0;
      eidx_r  <= '0;
      t_r     <= '0;
      cc_r    <= '0;
      sp_r    <= '0;
      msp_r   <= '0;
      root_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      addr_r  <= addr_nxt;
      cnt_r   <= cnt_nxt;
      eidx_r  <= eidx_nxt;
      t_r     <= t_nxt;
      cc_r    <= cc_nxt;
      sp_r    <= sp_nxt;
      msp_r   <= msp_nxt;
      root_r  <= root_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt; d_r <= d_nxt; vi_r <= vi_nxt;
    ls_r <= ls_nxt; ld_r <= ld_nxt;
    top_u_r <= top_u_nxt; top_k_r <= top_k_nxt; top_e_r <= top_e_nxt;
    w_r <= w_nxt; cf_r <= cf_nxt; clow_r <= clow_nxt; rec_r <= rec_nxt;
    o_status_r <= o_status_nxt; o_cc_r <= o_cc_nxt; o_pres_r <= o_pres_nxt;
    o_comp_r <= o_comp_nxt; o_disc_r <= o_disc_nxt; o_fin_r <= o_fin_nxt;
    o_low_r <= o_low_nxt; o_cross_r <= o_cross_nxt; o_cf_r <= o_cf_nxt;
    o_ct_r <= o_ct_nxt; o_es_r <= o_es_nxt; o_ed_r <= o_ed_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = o_status_r;
  assign out_comp_count  = o_cc_r;
  assign out_present     = o_pres_r;
  assign out_comp_id     = o_comp_r;
  assign out_disc_time   = o_disc_r;
  assign out_finish_time = o_fin_r;
  assign out_low_link    = o_low_r;
  assign out_is_cross    = o_cross_r;
  assign out_comp_from   = o_cf_r;
  assign out_comp_to     = o_ct_r;
  assign out_edge_src    = o_es_r;
  assign out_edge_dst    = o_ed_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NE)) else $error("edge count beyond store depth");

  a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= msp_r) else $error("search stack deeper than member stack");

  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE) else $error("result while still busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid) else $error("transaction lost");

endmodule
`default_nettype wire

@@ test/scc_labeling_engine_top_test.sv @@
// ----------------------------------------------------------------------------
// SCC labeling engine testbench
// Mostly sorted edge lists are loaded, searched and queried while a self-checking
// Tarjan predictor tracks every transaction. The result of each request is
// compared as a whole with the predicted one, in order.
// ----------------------------------------------------------------------------
module scc_labeling_engine_top_test;
  import scc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PNONE = 2047;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [2:0] REQ_BAD5 = 3'd5;
  localparam logic [2:0] REQ_BAD7 = 3'd7;

  typedef struct {
    logic [2:0]  req;
    logic [9:0]  src;
    logic [9:0]  dst;
    logic [9:0]  vidx;
    logic [11:0] eidx;
    int          gap;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] comp_count;
    logic        present;
    logic [9:0]  comp_id;
    logic [11:0] disc_time;
    logic [11:0] finish_time;
    logic [11:0] low_link;
    logic        is_cross;
    logic [9:0]  comp_from;
    logic [9:0]  comp_to;
    logic [9:0]  edge_src;
    logic [9:0]  edge_dst;
  } answer_t;

  logic clk, rst_n, start, busy, out_valid;
  logic [2:0] in_req_type;
  logic [9:0] in_src_vertex, in_dst_vertex, in_vertex_index;
  logic [11:0] in_edge_index;
  logic [1:0] out_status;
  logic [10:0] out_comp_count;
  logic out_present, out_is_cross;
  logic [9:0] out_comp_id, out_comp_from, out_comp_to, out_edge_src, out_edge_dst;
  logic [11:0] out_disc_time, out_finish_time, out_low_link;

  scc_labeling_engine_top u_top (.*);

  // predictor state
  int e_src[NE], e_dst[NE];
  int row[NV+1];
  bit v_pres[NV], v_stk[NV];
  int v_col[NV], v_disc[NV], v_fin[NV], v_low[NV], v_par[NV], v_comp[NV];
  int walk_v[NV], walk_k[NV], walk_dep;
  int memb[NV], memb_dep;
  int n_edges, clock_ticks, n_comps;

  request_t pending_q[$];
  answer_t  answer_q[$];
  int mismatches;
  int idle_cycles;
  logic acc_pulse;

  // stimulus-side mirror of what is stored and labeled
  int g_src[NE], g_dst[NE], g_cnt, g_items;
  bit g_pres[NV], g_lab[NV];

  function void wipe_search();
    for (int v = 0; v < NV; v++) begin
      v_col[v] = 0; v_disc[v] = 0; v_fin[v] = 0; v_low[v] = 0;
      v_stk[v] = 0; v_par[v] = PNONE;
    end
    walk_dep = 0; memb_dep = 0; clock_ticks = 0; n_comps = 0;
  endfunction

  function void wipe_graph();
    for (int v = 0; v < NV; v++) begin
      v_pres[v] = 0; v_comp[v] = 0;
    end
    n_edges = 0;
    wipe_search();
  endfunction

  function void visit(int v, int p);
    v_col[v] = 1;
    clock_ticks++;
    v_disc[v] = clock_ticks; v_low[v] = clock_ticks;
    v_par[v] = p; v_stk[v] = 1;
    memb[memb_dep++] = v;
    walk_v[walk_dep] = v; walk_k[walk_dep] = row[v]; walk_dep++;
  endfunction

  function void close_vertex(int u);
    int w, p;
    v_col[u] = 2;
    clock_ticks++;
    v_fin[u] = clock_ticks;
    walk_dep--;
    if (v_low[u] == v_disc[u]) begin
      while (memb_dep > 0) begin
        w = memb[--memb_dep];
        v_stk[w] = 0;
        v_comp[w] = n_comps;
        if (w == u) break;
      end
      n_comps++;
    end
    p = v_par[u];
    if (p < NV && v_low[u] < v_low[p]) v_low[p] = v_low[u];
  endfunction

  function void label_components();
    int e, u, k, w;
    e = 0;
    for (int v = 0; v <= NV; v++) begin
      while (e < n_edges && e_src[e] < v) e++;
      row[v] = e;
    end
    wipe_search();
    for (int r = 0; r < NV; r++) begin
      if (!v_pres[r] || v_col[r] != 0) continue;
      visit(r, PNONE);
      while (walk_dep > 0) begin
        u = walk_v[walk_dep-1];
        k = walk_k[walk_dep-1];
        if (k < row[u+1]) begin
          walk_k[walk_dep-1] = k + 1;
          w = e_dst[k];
          if (v_col[w] == 0) visit(w, u);
          else if (v_stk[w] && v_disc[w] < v_low[u]) v_low[u] = v_disc[w];
        end else begin
          close_vertex(u);
        end
      end
    end
  endfunction

  function answer_t serve(request_t rq);
    answer_t a;
    int s, d;
    a = '0;
    s = rq.src; d = rq.dst;
    case (rq.req)
      REQ_LOAD: begin
        if (n_edges >= NE) a.status = ST_FULL;
        else if (n_edges == 0 || s > e_src[n_edges-1] ||
                 (s == e_src[n_edges-1] && d > e_dst[n_edges-1])) begin
          e_src[n_edges] = s; e_dst[n_edges] = d; n_edges++;
          v_pres[s] = 1; v_pres[d] = 1;
        end
      end
      REQ_RUN: label_components();
      REQ_QVERT: begin
        a.present = v_pres[rq.vidx];
        a.comp_id = v_pres[rq.vidx] ? v_comp[rq.vidx] : 0;
        a.disc_time = v_disc[rq.vidx];
        a.finish_time = v_fin[rq.vidx];
        a.low_link = v_low[rq.vidx];
      end
      REQ_QEDGE: begin
        if (rq.eidx >= n_edges) a.status = ST_RANGE;
        else begin
          s = e_src[rq.eidx]; d = e_dst[rq.eidx];
          a.comp_from = v_comp[s]; a.comp_to = v_comp[d];
          a.is_cross = v_comp[s] != v_comp[d];
          a.edge_src = s; a.edge_dst = d;
        end
      end
      REQ_CLEAR: wipe_graph();
      default: ;
    endcase
    a.status = a.status;
    a.comp_count = n_comps;
    return a;
  endfunction

  // stimulus helpers
  function void add(logic [2:0] req, int s, int d, int vi, int ei, int gap);
    request_t rq;
    rq.req = req; rq.src = s; rq.dst = d; rq.vidx = vi; rq.eidx = ei; rq.gap = gap;
    if (req == REQ_LOAD && g_cnt < NE && (g_cnt == 0 || s > g_src[g_cnt-1] ||
        (s == g_src[g_cnt-1] && d > g_dst[g_cnt-1]))) begin
      g_src[g_cnt] = s; g_dst[g_cnt] = d; g_cnt++;
      g_pres[s] = 1; g_pres[d] = 1;
    end else if (req == REQ_RUN) begin
      for (int v = 0; v < NV; v++) g_lab[v] |= g_pres[v];
    end else if (req == REQ_CLEAR) begin
      g_cnt = 0;
      for (int v = 0; v < NV; v++) begin
        g_pres[v] = 0; g_lab[v] = 0;
      end
    end
    pending_q.push_back(rq);
    g_items++;
  endfunction

  function void add_op(logic [2:0] req, int gap);
    add(req, $urandom_range(0, 1023), $urandom_range(0, 1023),
        $urandom_range(0, 1023), $urandom_range(0, 4095), gap);
  endfunction

  function void add_vq(int v, int gap);
    if (g_pres[v] && !g_lab[v]) v = 0;
    if (g_pres[v] && !g_lab[v]) begin
      add_eq(g_cnt, gap);
      return;
    end
    add(REQ_QVERT, $urandom_range(0, 1023), $urandom_range(0, 1023), v,
        $urandom_range(0, 4095), gap);
  endfunction

  function void add_eq(int ei, int gap);
    if (ei < g_cnt && !(g_lab[g_src[ei]] && g_lab[g_dst[ei]])) ei = g_cnt;
    if (ei > 4095) ei = 4095;
    add(REQ_QEDGE, $urandom_range(0, 1023), $urandom_range(0, 1023),
        $urandom_range(0, 1023), ei, gap);
  endfunction

  function void add_load(int s, int d, int gap);
    add(REQ_LOAD, s, d, $urandom_range(0, 1023), $urandom_range(0, 4095), gap);
  endfunction

  function void build_phase();
    int gmax, span, stride, base, nq;
    gmax = ($urandom_range(0, 3) == 0) ? 0 : 12;
    if ($urandom_range(0, 4) != 0) add_op(REQ_CLEAR, $urandom_range(0, gmax));
    span = $urandom_range(2, 10);
    stride = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 1023 / span) : 1;
    base = $urandom_range(0, 1023 - (span - 1) * stride);
    for (int s = 0; s < span; s++)
      for (int d = 0; d < span; d++) begin
        if ($urandom_range(0, 2) == 0)
          add_load(base + s * stride, base + d * stride, $urandom_range(0, gmax));
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1)) add_load($urandom_range(0, 1023),
                                             $urandom_range(0, 1023), $urandom_range(0, gmax));
          else add_op($urandom_range(REQ_BAD5, REQ_BAD7), $urandom_range(0, gmax));
        end
      end
    add_op(REQ_RUN, $urandom_range(0, gmax));
    if ($urandom_range(0, 3) == 0)
      add_load($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, gmax));
    nq = $urandom_range(5, 25);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 1))
        add_vq($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) :
               base + $urandom_range(0, span - 1) * stride, $urandom_range(0, gmax));
      else
        add_eq($urandom_range(0, g_cnt + 2), $urandom_range(0, gmax));
    end
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  request_t cur;
  bit loaded;
  int gap_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !acc_pulse)) begin
      if (!loaded && pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        gap_left = cur.gap;
        loaded = 1;
      end
      if (loaded && gap_left == 0) begin
        start <= 1'b1;
        in_req_type <= cur.req;
        in_src_vertex <= cur.src;
        in_dst_vertex <= cur.dst;
        in_vertex_index <= cur.vidx;
        in_edge_index <= cur.eidx;
        loaded = 0;
      end else begin
        if (loaded) gap_left--;
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    request_t rq;
    answer_t got, want;
    if (rst_n) begin
      acc_pulse <= start && !busy;
      if (out_valid) begin
        got = '{out_status, out_comp_count, out_present, out_comp_id, out_disc_time,
                out_finish_time, out_low_link, out_is_cross, out_comp_from, out_comp_to,
                out_edge_src, out_edge_dst};
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (start && !busy) begin
        rq.req = in_req_type; rq.src = in_src_vertex; rq.dst = in_dst_vertex;
        rq.vidx = in_vertex_index; rq.eidx = in_edge_index; rq.gap = 0;
        answer_q.push_back(serve(rq));
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 0; start = 0; acc_pulse = 0; idle_cycles = 0; mismatches = 0; loaded = 0;
    in_req_type = REQ_LOAD; in_src_vertex = '0; in_dst_vertex = '0;
    in_vertex_index = '0; in_edge_index = '0;
    wipe_graph();
    g_cnt = 0; g_items = 0;
    for (int v = 0; v < NV; v++) begin
      g_pres[v] = 0; g_lab[v] = 0;
    end
    // directed
    add_vq(0, 0);
    add_eq(0, 0);
    add_eq(4095, 1);
    add_op(REQ_BAD5, 0);
    add_op(3'd6, 2);
    add_op(REQ_BAD7, 0);
    add_op(REQ_RUN, 0);
    add_load(0, 0, 0);
    add_load(0, 1, 0);
    add_load(0, 1, 0);
    add_load(0, 0, 3);
    add_load(1, 0, 0);
    add_load(1, 1023, 0);
    add_load(1023, 1023, 0);
    add_load(1023, 0, 0);
    add_op(REQ_RUN, 0);
    add_vq(0, 0);
    add_vq(1, 0);
    add_vq(1023, 0);
    add_vq(500, 0);
    for (int i = 0; i <= 4; i++) add_eq(i, 0);
    // fill the edge store to capacity
    add_op(REQ_CLEAR, 0);
    for (int i = 0; i < NE; i++)
      add(REQ_LOAD, i >> 2, (i & 3) * 256 + $urandom_range(0, 255),
          $urandom_range(0, 1023), $urandom_range(0, 4095), 0);
    add_load(1023, 1023, 0);
    add_op(REQ_RUN, 0);
    add_eq(4095, 0);
    add_eq(0, 0);
    add_eq($urandom_range(0, 4095), 0);
    add_vq(1023, 0);
    add_vq($urandom_range(0, 1023), 0);
    g_items = 0;
    while (g_items < 1850) build_phase();

    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (pending_q.size() > 0 || loaded || start || answer_q.size() > 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
